/* design/dci_pkg.sv */
// Package for the dual counter interval core: beat types, sideband types,
// register indexes and fixed constants. No dependencies.
package dci_pkg;

   localparam int DIV_W = 64;
   localparam int REM_W = 32;

   localparam logic [19:0] MICROS_PER_SECOND = 20'd1000000;
   localparam logic [31:0] FINE_WRAP         = 32'hFFFF_FFFF;

   // One million is 64 times 15625. A shift by six followed by a multiply by the
   // rounded-up reciprocal of 15625, scaled by 2**72, is exact for any 58-bit value.
   localparam logic [13:0]  MICRO_ODD_PART = 14'd15625;
   localparam logic [127:0] RECIP_SCALE    = 128'd1 << 72;
   localparam logic [127:0] RECIP_FULL     =
      (RECIP_SCALE + 128'(MICRO_ODD_PART) - 128'd1) / 128'(MICRO_ODD_PART);
   localparam logic [58:0]  MICRO_RECIP    = RECIP_FULL[58:0];

   localparam logic [1:0] ORDER_LESS    = 2'd0;
   localparam logic [1:0] ORDER_EQUAL   = 2'd1;
   localparam logic [1:0] ORDER_GREATER = 2'd2;

   localparam logic [1:0] REG_PERIOD = 2'd0;
   localparam logic [1:0] REG_FREQ   = 2'd1;
   localparam logic [1:0] REG_DIR    = 2'd2;

   localparam logic [19:0] PERIOD_RESET = 20'd1000;
   localparam logic [30:0] FREQ_RESET   = 31'd1000;

   typedef struct packed {
      logic [31:0] earlier_coarse;
      logic [31:0] earlier_fine;
      logic [31:0] later_coarse;
      logic [31:0] later_fine;
   } req_type;

   typedef struct packed {
      logic [31:0] coarse_interval;
      logic [63:0] fine_interval;
      logic [63:0] micro_interval;
      logic [1:0]  order;
      logic        negative_error;
   } rsp_type;

   typedef struct packed {
      logic [31:0] coarse;
      logic [31:0] step;
      logic [1:0]  order;
      logic        err;
   } side1_type;

   typedef struct packed {
      logic [31:0] coarse;
      logic [63:0] fine;
      logic [1:0]  order;
      logic        err;
   } side2_type;

endpackage

/* design/dual_counter_interval_core.sv */
// An accepted request beat passes through one row of 64 division cells and thirteen further
// pipeline stages on its way to its response beat.
// Throughput is one beat per cycle; the whole pipeline stalls only while a response
// beat waits at the output register.
// Synchronous reset empties the pipeline and loads the register reset values.
// Top level: depends on dci_pkg and dci_div_chain.
module dual_counter_interval_core
   import dci_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [19:0] period_ff;
   logic [30:0] freq_ff;
   logic        up_ff;
   logic [1:0]  csr_index;
   logic        adv;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
         freq_ff   <= FREQ_RESET;
         up_ff     <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_index)
            REG_PERIOD: period_ff <= csr_pwdata[19:0];
            REG_FREQ:   freq_ff   <= csr_pwdata[30:0];
            REG_DIR:    up_ff     <= csr_pwdata[0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_PERIOD: csr_prdata = {12'd0, period_ff};
         REG_FREQ:   csr_prdata = {1'b0, freq_ff};
         REG_DIR:    csr_prdata = {31'd0, up_ff};
         default:    csr_prdata = '0;
      endcase
   end

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   assign adv       = ~rsp_valid_ff | rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Stage A: differences, order and the wrapped fine step.
   logic      a_valid_ff;
   side1_type a_side_ff;
   side1_type a_side_in;
   logic      err;
   logic [31:0] from_val;
   logic [31:0] to_val;

   always_comb begin
      err      = req_data.earlier_coarse > req_data.later_coarse;
      from_val = up_ff ? req_data.earlier_fine : req_data.later_fine;
      to_val   = up_ff ? req_data.later_fine : req_data.earlier_fine;
      priority if (req_data.later_coarse > req_data.earlier_coarse) begin
         a_side_in.order = ORDER_GREATER;
      end else if (req_data.later_coarse < req_data.earlier_coarse) begin
         a_side_in.order = ORDER_LESS;
      end else if (req_data.later_fine == req_data.earlier_fine) begin
         a_side_in.order = ORDER_EQUAL;
      end else begin
         a_side_in.order = (to_val > from_val) ? ORDER_GREATER : ORDER_LESS;
      end
      a_side_in.err = err;
      if (err) begin
         a_side_in.coarse = '0;
         a_side_in.step   = '0;
      end else begin
         a_side_in.coarse = req_data.later_coarse - req_data.earlier_coarse;
         priority if (from_val < to_val) begin
            a_side_in.step = to_val - from_val;
         end else if (from_val > to_val) begin
            a_side_in.step = to_val + (FINE_WRAP - from_val);
         end else begin
            a_side_in.step = '0;
         end
      end
   end

   // Stages B to D: coarse ticks times period times frequency, wrapped at 64 bits.
   logic        b_valid_ff, c_valid_ff, d_valid_ff;
   side1_type   b_side_ff, c_side_ff, d_side_ff;
   logic [51:0] b_prod_ff;
   logic [62:0] c_lo_ff;
   logic [31:0] c_hi_ff;
   logic [63:0] d_num_ff;
   logic [50:0] c_hi_full;

   assign c_hi_full = 51'(b_prod_ff[51:32]) * 51'(freq_ff);

   // Stages P to R: divide by one million as a shift by six and a reciprocal multiply.
   logic        p_valid_ff, q_valid_ff, r_valid_ff;
   side1_type   p_side_ff, q_side_ff, r_side_ff;
   logic [63:0] p_ll_ff;
   logic [58:0] p_lh_ff;
   logic [57:0] p_hl_ff;
   logic [52:0] p_hh_ff;
   logic [60:0] q_mid_ff;
   logic [52:0] q_hh_ff;
   logic [63:0] r_quot_ff;
   logic [57:0] scaled;
   logic [53:0] r_sum;

   assign scaled = d_num_ff[63:6];
   assign r_sum  = {1'b0, q_hh_ff} + 54'(q_mid_ff[60:32]);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         p_valid_ff <= 1'b0;
         q_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         p_valid_ff <= d_valid_ff;
         q_valid_ff <= p_valid_ff;
         r_valid_ff <= q_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_side_ff <= a_side_in;
         b_side_ff <= a_side_ff;
         b_prod_ff <= 52'(a_side_ff.coarse) * 52'(period_ff);
         c_side_ff <= b_side_ff;
         c_lo_ff   <= 63'(b_prod_ff[31:0]) * 63'(freq_ff);
         c_hi_ff   <= c_hi_full[31:0];
         d_side_ff <= c_side_ff;
         d_num_ff  <= 64'(c_lo_ff) + {c_hi_ff, 32'd0};
         p_side_ff <= d_side_ff;
         p_ll_ff   <= 64'(scaled[31:0]) * 64'(MICRO_RECIP[31:0]);
         p_lh_ff   <= 59'(scaled[31:0]) * 59'(MICRO_RECIP[58:32]);
         p_hl_ff   <= 58'(scaled[57:32]) * 58'(MICRO_RECIP[31:0]);
         p_hh_ff   <= 53'(scaled[57:32]) * 53'(MICRO_RECIP[58:32]);
         q_side_ff <= p_side_ff;
         q_mid_ff  <= 61'(p_lh_ff) + 61'(p_hl_ff) + 61'(p_ll_ff[63:32]);
         q_hh_ff   <= p_hh_ff;
         r_side_ff <= q_side_ff;
         r_quot_ff <= 64'(r_sum[53:8]);
      end
   end

   // Stages E to I: round down to a multiple of the wrap, add the step, scale.
   logic        e_valid_ff, f_valid_ff, g_valid_ff, h_valid_ff, i_valid_ff;
   side1_type   e_side_ff, f_side_ff;
   side2_type   g_side_ff, h_side_ff, i_side_ff;
   logic [63:0] e_quot_ff, f_quot_ff;
   logic [32:0] e_sum_ff;
   logic [31:0] f_mod_ff;
   logic [31:0] fold;
   logic [51:0] h_lo_ff;
   logic [31:0] h_hi_ff;
   logic [51:0] h_hi_full;
   logic [63:0] i_num_ff;
   side2_type   g_side_in;

   assign fold      = e_sum_ff[31:0] + {31'd0, e_sum_ff[32]};
   assign h_hi_full = 52'(g_side_ff.fine[63:32]) * 52'(MICROS_PER_SECOND);

   always_comb begin
      g_side_in.coarse = f_side_ff.coarse;
      g_side_in.fine   = f_quot_ff - 64'(f_mod_ff) + 64'(f_side_ff.step);
      g_side_in.order  = f_side_ff.order;
      g_side_in.err    = f_side_ff.err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
         h_valid_ff <= 1'b0;
         i_valid_ff <= 1'b0;
      end else if (adv) begin
         e_valid_ff <= r_valid_ff;
         f_valid_ff <= e_valid_ff;
         g_valid_ff <= f_valid_ff;
         h_valid_ff <= g_valid_ff;
         i_valid_ff <= h_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_side_ff <= r_side_ff;
         e_quot_ff <= r_quot_ff;
         e_sum_ff  <= {1'b0, r_quot_ff[63:32]} + {1'b0, r_quot_ff[31:0]};
         f_side_ff <= e_side_ff;
         f_quot_ff <= e_quot_ff;
         f_mod_ff  <= (fold == FINE_WRAP) ? 32'd0 : fold;
         g_side_ff <= g_side_in;
         h_side_ff <= g_side_ff;
         h_lo_ff   <= 52'(g_side_ff.fine[31:0]) * 52'(MICROS_PER_SECOND);
         h_hi_ff   <= h_hi_full[31:0];
         i_side_ff <= h_side_ff;
         i_num_ff  <= 64'(h_lo_ff) + {h_hi_ff, 32'd0};
      end
   end

   logic        q2_valid;
   logic [63:0] q2_quot;
   side2_type   q2_side;

   dci_div_chain #(.SIDE_W($bits(side2_type))) u_div_freq (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .divisor   ({1'b0, freq_ff}),
      .in_valid  (i_valid_ff),
      .in_num    (i_num_ff),
      .in_side   (i_side_ff),
      .out_valid (q2_valid),
      .out_quot  (q2_quot),
      .out_side  (q2_side)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= q2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff.coarse_interval <= q2_side.coarse;
         rsp_data_ff.fine_interval   <= q2_side.fine;
         rsp_data_ff.micro_interval  <= (freq_ff == '0) ? 64'd0 : q2_quot;
         rsp_data_ff.order           <= q2_side.order;
         rsp_data_ff.negative_error  <= q2_side.err;
      end
   end

endmodule

/* design/dci_div_cell.sv */
// One restoring division cell: retires one quotient bit per beat.
// Depends on dci_pkg.
module dci_div_cell
   import dci_pkg::*;
#(
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic [REM_W-1:0]  divisor,
   input  logic              in_valid,
   input  logic [REM_W-1:0]  in_rem,
   input  logic [DIV_W-1:0]  in_num,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid_ff,
   output logic [REM_W-1:0]  out_rem_ff,
   output logic [DIV_W-1:0]  out_num_ff,
   output logic [SIDE_W-1:0] out_side_ff
);

   logic [REM_W:0]   trial;
   logic [REM_W:0]   diff;
   logic             ge;
   logic [REM_W-1:0] rem_in;
   logic [DIV_W-1:0] num_in;

   always_comb begin
      trial  = {in_rem, in_num[DIV_W-1]};
      diff   = trial - {1'b0, divisor};
      ge     = ~diff[REM_W];
      rem_in = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      num_in = {in_num[DIV_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_rem_ff  <= rem_in;
         out_num_ff  <= num_in;
         out_side_ff <= in_side;
      end
   end

endmodule

/* design/dci_div_chain.sv */
// Row of division cells giving a 64-bit quotient after one cell per bit.
// Depends on dci_pkg and dci_div_cell.
module dci_div_chain
   import dci_pkg::*;
#(
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic [REM_W-1:0]  divisor,
   input  logic              in_valid,
   input  logic [DIV_W-1:0]  in_num,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [DIV_W-1:0]  out_quot,
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_w [DIV_W+1];
   logic [REM_W-1:0]  rem_w   [DIV_W+1];
   logic [DIV_W-1:0]  num_w   [DIV_W+1];
   logic [SIDE_W-1:0] side_w  [DIV_W+1];

   assign valid_w[0] = in_valid;
   assign rem_w[0]   = '0;
   assign num_w[0]   = in_num;
   assign side_w[0]  = in_side;

   for (genvar i = 0; i < DIV_W; i++) begin : g_cell
      dci_div_cell #(.SIDE_W(SIDE_W)) u_cell (
         .clock        (clock),
         .reset        (reset),
         .adv          (adv),
         .divisor      (divisor),
         .in_valid     (valid_w[i]),
         .in_rem       (rem_w[i]),
         .in_num       (num_w[i]),
         .in_side      (side_w[i]),
         .out_valid_ff (valid_w[i+1]),
         .out_rem_ff   (rem_w[i+1]),
         .out_num_ff   (num_w[i+1]),
         .out_side_ff  (side_w[i+1])
      );
   end

   assign out_valid = valid_w[DIV_W];
   assign out_quot  = num_w[DIV_W];
   assign out_side  = side_w[DIV_W];

endmodule

/* design/dci_checker.sv */
// Port-level checks for the dual counter interval core, with the bind that attaches them.
// Depends on dci_pkg and dual_counter_interval_core.
module dci_checker
   import dci_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data,
   input logic    csr_pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("Response beat changed while stalled.");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.negative_error |->
         rsp_data.coarse_interval == '0 && rsp_data.fine_interval == '0 &&
         rsp_data.micro_interval == '0)
      else $error("Error beat carries a non-zero interval.");

   a_err_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.negative_error |-> rsp_data.order == ORDER_LESS)
      else $error("Error beat does not report the later stamp as less.");

   a_coarse_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.coarse_interval != '0 |-> rsp_data.order == ORDER_GREATER)
      else $error("Positive coarse interval with wrong order.");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("Register port stalled.");

endmodule

bind dual_counter_interval_core dci_checker u_dci_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_data   (rsp_data),
   .csr_pready (csr_pready)
);

/* dv/tb.sv */
// Self-checking testbench for dual_counter_interval_core: a scoreboard class predicts each
// response beat from the request beat and the current register settings.
// Depends on dci_pkg and the core with its division chain.
module tb;
   import dci_pkg::*;

   class interval_scoreboard;
      logic [63:0] period_us;
      logic [63:0] freq_hz;
      logic        counts_up;
      rsp_type     expected_q[$];
      int          failures;
      int          checked;
      int          errors_seen;

      function new();
         period_us = 64'(PERIOD_RESET);
         freq_hz = 64'(FREQ_RESET);
         counts_up = 1'b0;
         failures = 0;
         checked = 0;
         errors_seen = 0;
      endfunction

      function logic [63:0] advance(logic [31:0] from_v, logic [31:0] to_v);
         if (from_v < to_v) return 64'(to_v) - 64'(from_v);
         if (from_v > to_v) return 64'(to_v) + (64'(FINE_WRAP) - 64'(from_v));
         return 64'd0;
      endfunction

      function rsp_type interval_of(req_type r);
         logic [63:0] span;
         logic [63:0] ticks;
         rsp_type p;
         p = '0;
         if (r.later_coarse > r.earlier_coarse) p.order = ORDER_GREATER;
         else if (r.later_coarse < r.earlier_coarse) p.order = ORDER_LESS;
         else if (r.later_fine == r.earlier_fine) p.order = ORDER_EQUAL;
         else if (counts_up)
            p.order = (r.later_fine > r.earlier_fine) ? ORDER_GREATER : ORDER_LESS;
         else
            p.order = (r.later_fine < r.earlier_fine) ? ORDER_GREATER : ORDER_LESS;
         if (r.earlier_coarse > r.later_coarse) begin
            p.negative_error = 1'b1;
         end else begin
            span = 64'(r.later_coarse - r.earlier_coarse);
            ticks = span * period_us;
            ticks = ticks * freq_hz;
            ticks = ticks / 64'(MICROS_PER_SECOND);
            ticks = (ticks / 64'(FINE_WRAP)) * 64'(FINE_WRAP);
            if (counts_up) ticks = ticks + advance(r.earlier_fine, r.later_fine);
            else ticks = ticks + advance(r.later_fine, r.earlier_fine);
            p.coarse_interval = span[31:0];
            p.fine_interval = ticks;
            if (freq_hz != 64'd0) p.micro_interval = (ticks * 64'(MICROS_PER_SECOND)) / freq_hz;
         end
         return p;
      endfunction

      function void note_request(req_type r);
         expected_q.push_back(interval_of(r));
      endfunction

      function void check_response(rsp_type a);
         rsp_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response beat %h", $time, a);
            failures++;
            return;
         end
         e = expected_q.pop_front();
         checked++;
         if (e.negative_error) errors_seen++;
         if (a.coarse_interval !== e.coarse_interval) begin
            $display("%0t: coarse_interval expected %h actual %h", $time,
                     e.coarse_interval, a.coarse_interval);
            failures++;
         end
         if (a.fine_interval !== e.fine_interval) begin
            $display("%0t: fine_interval expected %h actual %h", $time,
                     e.fine_interval, a.fine_interval);
            failures++;
         end
         if (a.micro_interval !== e.micro_interval) begin
            $display("%0t: micro_interval expected %h actual %h", $time,
                     e.micro_interval, a.micro_interval);
            failures++;
         end
         if (a.order !== e.order) begin
            $display("%0t: order expected %h actual %h", $time, e.order, a.order);
            failures++;
         end
         if (a.negative_error !== e.negative_error) begin
            $display("%0t: negative_error expected %h actual %h", $time,
                     e.negative_error, a.negative_error);
            failures++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   interval_scoreboard sb = new();
   bit quiet_tail = 1'b0;
   int idle_cycles = 0;
   int items_sent = 0;

   dual_counter_interval_core dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 4000) begin
         $display("dual_counter_interval_core: mismatch");
         $finish;
      end
   end

   initial begin
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   task automatic write_reg(logic [1:0] index, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         REG_PERIOD: sb.period_us = 64'(value[19:0]);
         REG_FREQ: sb.freq_hz = 64'(value[30:0]);
         REG_DIR: sb.counts_up = value[0];
         default: ;
      endcase
   endtask

   task automatic set_mode(logic [31:0] period, logic [31:0] freq, logic up);
      write_reg(REG_PERIOD, period);
      write_reg(REG_FREQ, freq);
      write_reg(REG_DIR, {31'd0, up});
      @(posedge clock);
   endtask

   task automatic send_item(req_type item);
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      sb.note_request(item);
      items_sent++;
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (160) @(posedge clock);
   endtask

   task automatic send_directed();
      req_type r;
      send_item('{32'd0, 32'd0, 32'd0, 32'd0});
      send_item('{32'd0, 32'd5, 32'd0, 32'd9});
      send_item('{32'd0, 32'd9, 32'd0, 32'd5});
      send_item('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
      send_item('{32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0});
      send_item('{32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
      send_item('{32'd10, 32'd3, 32'd9, 32'd3});
      send_item('{32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF});
      send_item('{32'd100, 32'd7, 32'd101, 32'd7});
      r = '{$urandom, $urandom, $urandom, $urandom};
      r.later_coarse = r.earlier_coarse + 32'd4000;
      send_item(r);
      send_item('{32'h1234_5678, 32'hAAAA_AAAA, 32'h1234_5678, 32'h5555_5555});
   endtask

   task automatic send_random(int count);
      req_type r;
      int kind;
      for (int i = 0; i < count; i++) begin
         r = '{$urandom, $urandom, $urandom, $urandom};
         kind = $urandom_range(0, 9);
         case (kind)
            0: ;
            1: r.later_coarse = r.earlier_coarse;
            2: r.later_fine = r.earlier_fine;
            3: r.later_coarse = r.earlier_coarse - $urandom_range(1, 50);
            4: r.later_coarse = r.earlier_coarse + $urandom;
            default: r.later_coarse = r.earlier_coarse + $urandom_range(0, 5000);
         endcase
         if (r.later_coarse < r.earlier_coarse && kind != 0 && kind != 3)
            r.earlier_coarse = r.earlier_coarse - 32'h8000_0000;
         send_item(r);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_directed();
      send_random(120);
      drain();
      set_mode(32'd1, 32'd1, 1'b1);
      send_directed();
      send_random(110);
      drain();
      set_mode(32'hF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_random(110);
      drain();
      set_mode(32'd0, 32'd0, 1'b1);
      send_random(60);
      drain();
      set_mode(32'd1_000_000, 32'd1, 1'b0);
      send_random(100);
      drain();
      set_mode($urandom_range(1, 1_000_000), $urandom_range(1, 32'h7FFF_FFFF), 1'b1);
      send_random(120);
      drain();
      quiet_tail = 1'b1;
      set_mode($urandom_range(1, 5000), $urandom_range(1, 100_000_000), 1'b0);
      send_random(150);
      drain();
      $display("Sent %0d request beats over seven register settings, counting up and down.",
               items_sent);
      $display("Checked %0d response beats, %0d of them with a negative coarse interval.",
               sb.checked, sb.errors_seen);
      if (sb.failures == 0 && sb.expected_q.size() == 0) begin
         $display("dual_counter_interval_core: match");
      end else begin
         $display("dual_counter_interval_core: mismatch");
      end
      $finish;
   end
endmodule

/* filelist.f */
design/dci_pkg.sv
design/dci_div_cell.sv
design/dci_div_chain.sv
design/dual_counter_interval_core.sv
design/dci_checker.sv
dv/tb.sv
